// File: sv/sprite_store_transform_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Sprite store assertion macros
// Concurrent check wrappers; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef SPRITE_STORE_TRANSFORM_ENGINE_UNIT_ASSERT_SVH
`define SPRITE_STORE_TRANSFORM_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SSTE_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("sste assertion failed");
`define SSTE_ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("sste assertion failed");
`else
`define SSTE_ASSERT_IMP(lbl, clk, rstn, a, b)
`define SSTE_ASSERT_NXT(lbl, clk, rstn, a, b)
`endif
`endif

// File: sv/sste_pkg.sv
// ----------------------------------------------------------------------------
// Sprite store package
// Command codes, status codes, sequencer states and register map.
// ----------------------------------------------------------------------------
package sste_pkg;

    typedef enum logic [3:0] {
        OP_WRITE_PIXEL = 4'd0,
        OP_READ_PIXEL  = 4'd1,
        OP_CLEAR       = 4'd2,
        OP_COPY        = 4'd3,
        OP_PASTE       = 4'd4,
        OP_SET_PAL     = 4'd5,
        OP_READ_PAL    = 4'd6,
        OP_ROT_LEFT    = 4'd7,
        OP_ROT_RIGHT   = 4'd8,
        OP_ROT_UP      = 4'd9,
        OP_ROT_DOWN    = 4'd10,
        OP_FLIP_H      = 4'd11,
        OP_FLIP_V      = 4'd12
    } t_op;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_CHECK,
        S_PALW,
        S_DIV,
        S_PIX_RD,
        S_PIX_WR,
        S_SAVE_RD,
        S_SAVE_WR,
        S_ROW_RD,
        S_ROW_WR,
        S_LAST,
        S_DONE
    } t_state;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_SPRITE  = 2'd1;
    localparam logic [1:0] ST_BAD_PIXEL   = 2'd2;

    localparam int        PADDR_W          = 3;
    localparam logic [PADDR_W-1:0] ADDR_SPRITES_IN_USE = 3'd0;

endpackage

// File: sv/sste_ram.sv
// ----------------------------------------------------------------------------
// Sprite store RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/sprite_store_transform_engine_unit.sv
// ----------------------------------------------------------------------------
// Sprite store transform engine
// Sprite pixel store with copy buffer, palettes and whole-sprite transforms.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  command   i_valid/o_stall, operation, sprite, pixel, val  in
//  result    o_valid/i_stall, read_value, status             out
//  config    psel/penable/pwrite/paddr/pwdata/prdata/pready  APB
//
//  Pixel commands find the row by repeated subtract. Row commands read and
//  write each row in turn; copy adds a palette step, rotate up/down save
//  one row first, vertical flip works per row pair; all are paced by the
//  single row RAM port.
//  After reset a clearing pass over all SPRITE_SLOTS*SPRITE_HEIGHT rows runs
//  with o_stall high. One command at a time; a finished result waits in
//  the output register while the next command is taken.
module sprite_store_transform_engine_unit
    import sste_pkg::*;
#(
    parameter int SPRITE_WIDTH  = 16,
    parameter int SPRITE_HEIGHT = 16,
    parameter int SPRITE_SLOTS  = 64,
    parameter int PIXEL_BITS    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_operation,
    input  logic [5:0]         i_sprite_number,
    input  logic [7:0]         i_pixel_number,
    input  logic [7:0]         i_write_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_read_value,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
`include "sprite_store_transform_engine_unit_assert.svh"

    localparam int RB   = SPRITE_WIDTH * PIXEL_BITS;
    localparam int ROWS = SPRITE_SLOTS * SPRITE_HEIGHT;
    localparam int AW   = $clog2(ROWS);
    localparam int RW   = $clog2(SPRITE_HEIGHT);
    localparam int CW   = $clog2(SPRITE_WIDTH);
    localparam int SW   = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
    localparam int PIX  = SPRITE_WIDTH * SPRITE_HEIGHT;
    localparam logic [RW-1:0] H_LAST = RW'(SPRITE_HEIGHT - 1);
    localparam logic [RW-1:0] H_PRE  = RW'(SPRITE_HEIGHT - 2);
    localparam logic [RW-1:0] H_HALF = RW'(SPRITE_HEIGHT / 2 - 1);

    t_state            r_state, n_state;
    t_op               r_op;
    logic [AW-1:0]     r_cnt;
    logic [SW-1:0]     r_sn;
    logic [AW-1:0]     r_base;
    logic [7:0]        r_col;
    logic [RW-1:0]     r_k;
    logic [7:0]        r_wv;
    logic [7:0]        r_rd;
    logic [1:0]        r_status;
    logic [RB-1:0]     r_temp;
    logic [7:0]        r_bufpal;
    logic [6:0]        r_siu;
    logic              r_ovalid;
    logic [7:0]        r_oread;
    logic [1:0]        r_ostatus;

    logic              accept, cfg_wr, out_load;
    logic              bad_sprite, bad_pixel;
    logic [RW-1:0]     src_row, dst_row, save_row, last_row;
    logic              row_last;

    logic              px_we;
    logic [AW-1:0]     px_waddr, px_raddr;
    logic [RB-1:0]     px_wdata, px_rdata;
    logic              buf_we;
    logic [RW-1:0]     buf_waddr;
    logic [RB-1:0]     buf_wdata, buf_rdata;
    logic              pal_we;
    logic [SW-1:0]     pal_waddr;
    logic [7:0]        pal_wdata, pal_rdata;

    logic [RB-1:0]     rot_l, rot_r, flip_h, pix_row;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_SPRITES_IN_USE) ? {25'd0, r_siu} : 32'd0;

    // unused codes finish with status ok whatever the sprite number
    assign bad_sprite = (i_operation <= OP_FLIP_V) &&
                        (({1'b0, i_sprite_number} >= r_siu) ||
                         (9'(i_sprite_number) >= 9'(SPRITE_SLOTS)));
    assign bad_pixel  = (32'(i_pixel_number) >= 32'(PIX)) &&
                        ((i_operation == OP_WRITE_PIXEL) ||
                         (i_operation == OP_READ_PIXEL));

    // row transforms are pure wiring
    always_comb begin
        for (int i = 0; i < SPRITE_WIDTH; i++) begin
            rot_l[i*PIXEL_BITS +: PIXEL_BITS] =
                px_rdata[((i + 1) % SPRITE_WIDTH)*PIXEL_BITS +: PIXEL_BITS];
            rot_r[i*PIXEL_BITS +: PIXEL_BITS] =
                px_rdata[((i + SPRITE_WIDTH - 1) % SPRITE_WIDTH)*PIXEL_BITS +: PIXEL_BITS];
            flip_h[i*PIXEL_BITS +: PIXEL_BITS] =
                px_rdata[(SPRITE_WIDTH - 1 - i)*PIXEL_BITS +: PIXEL_BITS];
        end
        pix_row = px_rdata;
        pix_row[r_col[CW-1:0]*PIXEL_BITS +: PIXEL_BITS] = r_wv[PIXEL_BITS-1:0];
    end

    // row schedule per command
    always_comb begin
        src_row  = r_k;
        dst_row  = r_k;
        save_row = r_k;
        last_row = H_LAST - r_k;
        row_last = (r_k == H_LAST);
        case (r_op)
            OP_ROT_UP: begin
                src_row  = r_k + RW'(1);
                save_row = '0;
                last_row = H_LAST;
                row_last = (r_k == H_PRE);
            end
            OP_ROT_DOWN: begin
                src_row  = H_PRE - r_k;
                dst_row  = H_LAST - r_k;
                save_row = H_LAST;
                last_row = '0;
                row_last = (r_k == H_PRE);
            end
            OP_FLIP_V: begin
                src_row  = H_LAST - r_k;
                row_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        out_load  = 1'b0;
        px_we     = 1'b0;
        px_waddr  = r_base + AW'(dst_row);
        px_wdata  = px_rdata;
        px_raddr  = r_base + AW'(src_row);
        buf_we    = 1'b0;
        buf_waddr = dst_row;
        buf_wdata = px_rdata;
        pal_we    = 1'b0;
        pal_waddr = r_sn;
        pal_wdata = r_wv;
        unique case (r_state)
            S_CLR: begin
                px_we     = 1'b1;
                px_waddr  = r_cnt;
                px_wdata  = '0;
                buf_we    = ({1'b0, r_cnt} < (AW+1)'(SPRITE_HEIGHT));
                buf_waddr = r_cnt[RW-1:0];
                buf_wdata = '0;
                pal_we    = ({1'b0, r_cnt} < (AW+1)'(SPRITE_SLOTS));
                pal_waddr = r_cnt[SW-1:0];
                pal_wdata = '0;
                if (r_cnt == AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_status != ST_OK) begin
                    n_state = S_DONE;
                end else begin
                    case (r_op) inside
                        OP_WRITE_PIXEL, OP_READ_PIXEL: n_state = S_DIV;
                        OP_SET_PAL: begin
                            pal_we  = 1'b1;
                            n_state = S_DONE;
                        end
                        OP_READ_PAL, OP_COPY: n_state = S_PALW;
                        OP_PASTE: begin
                            pal_we    = 1'b1;
                            pal_wdata = r_bufpal;
                            n_state   = S_ROW_RD;
                        end
                        OP_CLEAR, OP_ROT_LEFT, OP_ROT_RIGHT, OP_FLIP_H:
                            n_state = S_ROW_RD;
                        OP_ROT_UP, OP_ROT_DOWN, OP_FLIP_V: n_state = S_SAVE_RD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PALW: begin
                n_state = (r_op == OP_COPY) ? S_ROW_RD : S_DONE;
            end
            S_DIV: begin
                if (r_col < 8'(SPRITE_WIDTH)) begin
                    n_state = S_PIX_RD;
                end
            end
            S_PIX_RD: begin
                n_state = S_PIX_WR;
            end
            S_PIX_WR: begin
                px_we    = (r_op == OP_WRITE_PIXEL);
                px_wdata = pix_row;
                n_state  = S_DONE;
            end
            S_SAVE_RD: begin
                px_raddr = r_base + AW'(save_row);
                n_state  = S_SAVE_WR;
            end
            S_SAVE_WR: begin
                n_state = S_ROW_RD;
            end
            S_ROW_RD: begin
                n_state = S_ROW_WR;
            end
            S_ROW_WR: begin
                px_we = (r_op != OP_COPY);
                buf_we = (r_op == OP_COPY);
                case (r_op)
                    OP_CLEAR:     px_wdata = '0;
                    OP_PASTE:     px_wdata = buf_rdata;
                    OP_ROT_LEFT:  px_wdata = rot_l;
                    OP_ROT_RIGHT: px_wdata = rot_r;
                    OP_FLIP_H:    px_wdata = flip_h;
                    default:      px_wdata = px_rdata;
                endcase
                if (row_last) begin
                    if (r_op == OP_ROT_UP || r_op == OP_ROT_DOWN || r_op == OP_FLIP_V) begin
                        n_state = S_LAST;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_ROW_RD;
                end
            end
            S_LAST: begin
                px_we    = 1'b1;
                px_waddr = r_base + AW'(last_row);
                px_wdata = r_temp;
                if (r_op == OP_FLIP_V && r_k != H_HALF) begin
                    n_state = S_SAVE_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_siu    <= '0;
            r_ovalid <= 1'b0;
            r_bufpal <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (cfg_wr && paddr == ADDR_SPRITES_IN_USE) begin
                r_siu <= pwdata[6:0];
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_PALW && r_op == OP_COPY) begin
                r_bufpal <= pal_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_op'(i_operation);
            r_sn     <= SW'(i_sprite_number);
            r_base   <= AW'(SW'(i_sprite_number)) * AW'(SPRITE_HEIGHT);
            r_col    <= i_pixel_number;
            r_k      <= '0;
            r_wv     <= i_write_value;
            r_rd     <= '0;
            r_status <= bad_sprite ? ST_BAD_SPRITE : (bad_pixel ? ST_BAD_PIXEL : ST_OK);
        end
        if (r_state == S_DIV && r_col >= 8'(SPRITE_WIDTH)) begin
            r_col <= r_col - 8'(SPRITE_WIDTH);
            r_k   <= r_k + RW'(1);
        end
        if ((r_state == S_ROW_WR && !row_last) ||
            (r_state == S_LAST && r_op == OP_FLIP_V)) begin
            r_k <= r_k + RW'(1);
        end
        if (r_state == S_SAVE_WR) begin
            r_temp <= px_rdata;
        end
        if (r_state == S_PIX_WR && r_op == OP_READ_PIXEL) begin
            r_rd <= 8'(px_rdata[r_col[CW-1:0]*PIXEL_BITS +: PIXEL_BITS]);
        end
        if (r_state == S_PALW && r_op == OP_READ_PAL) begin
            r_rd <= pal_rdata;
        end
        if (out_load) begin
            r_oread   <= r_rd;
            r_ostatus <= r_status;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_read_value = r_oread;
    assign o_status     = r_ostatus;

    sste_ram #(.WIDTH(RB), .DEPTH(ROWS), .AW(AW)) u_px_ram (
        .i_clk   (i_clk),
        .i_we    (px_we),
        .i_waddr (px_waddr),
        .i_wdata (px_wdata),
        .i_raddr (px_raddr),
        .o_rdata (px_rdata)
    );

    sste_ram #(.WIDTH(RB), .DEPTH(SPRITE_HEIGHT), .AW(RW)) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (src_row),
        .o_rdata (buf_rdata)
    );

    sste_ram #(.WIDTH(8), .DEPTH(SPRITE_SLOTS), .AW(SW)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wdata),
        .i_raddr (r_sn),
        .o_rdata (pal_rdata)
    );

    `SSTE_ASSERT_IMP(a_no_result_in_clear, i_clk, i_rst_n, r_state == S_CLR, !r_ovalid)
    `SSTE_ASSERT_NXT(a_accept_to_check, i_clk, i_rst_n, accept, r_state == S_CHECK)
    `SSTE_ASSERT_IMP(a_row_in_range, i_clk, i_rst_n, r_state == S_ROW_WR, r_k <= H_LAST)

endmodule
